// ===== sv/i2cms_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types, codes and action tables for the I2C master bit sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cms_pkg;

  localparam int BYTE_W    = 8;
  localparam int BIT_IDX_W = $clog2(BYTE_W);
  localparam int PHASE_W   = 10;
  localparam int STEP_W    = 4;
  localparam int OP_W      = 3;

  localparam logic [BIT_IDX_W-1:0] LAST_BIT    = BIT_IDX_W'(BYTE_W - 1);
  localparam logic [PHASE_W-1:0]   PHASE_RESET = PHASE_W'(10);

  // sequence step codes: 0..3 index the next action
  localparam logic [STEP_W-1:0] ST_FIRST = 4'd0;
  localparam logic [STEP_W-1:0] ST_FINAL = 4'd14;
  localparam logic [STEP_W-1:0] ST_IDLE  = 4'd15;

  localparam logic [OP_W-1:0] OP_START = 3'd0;
  localparam logic [OP_W-1:0] OP_STOP  = 3'd1;
  localparam logic [OP_W-1:0] OP_WRITE = 3'd2;
  localparam logic [OP_W-1:0] OP_READ  = 3'd3;
  localparam logic [OP_W-1:0] OP_SACK  = 3'd4;
  localparam logic [OP_W-1:0] OP_RACK  = 3'd5;

  typedef enum logic [2:0] {
    A_SDA0,
    A_SDA1,
    A_SDA_BIT,
    A_SDA_ACK,
    A_SCL0,
    A_SCL1,
    A_READ_BIT,
    A_READ_ACK
  } act_t;

  typedef struct packed {
    logic [STEP_W-1:0]    seq_step;
    logic [OP_W-1:0]      current_op;
    logic [BIT_IDX_W-1:0] bit_index;
    logic [BYTE_W-1:0]    shift_out;
    logic [BYTE_W-1:0]    shift_in;
    logic [PHASE_W-1:0]   phase_count;
    logic                 scl_level;
    logic                 sda_level;
    logic                 ack_seen;
  } seq_state_t;

  typedef struct packed {
    logic              cmd_valid;
    logic [OP_W-1:0]   opcode;
    logic [BYTE_W-1:0] tx_byte;
    logic              tx_ack;
    logic              sda_in;
  } cmd_t;

  // line action for a given command and step
  function automatic act_t action_at(input logic [OP_W-1:0] op, input logic [1:0] step);
    act_t a;
    a = A_SDA1;
    case (op)
      OP_STOP: begin
        case (step)
          2'd0:    a = A_SDA0;
          2'd1:    a = A_SCL1;
          default: a = A_SDA1;
        endcase
      end
      OP_WRITE: begin
        case (step)
          2'd0:    a = A_SDA_BIT;
          2'd1:    a = A_SCL1;
          default: a = A_SCL0;
        endcase
      end
      OP_READ: begin
        case (step)
          2'd0:    a = A_SDA1;
          2'd1:    a = A_SCL1;
          2'd2:    a = A_READ_BIT;
          default: a = A_SCL0;
        endcase
      end
      OP_SACK: begin
        case (step)
          2'd0:    a = A_SDA_ACK;
          2'd1:    a = A_SCL1;
          default: a = A_SCL0;
        endcase
      end
      OP_RACK: begin
        case (step)
          2'd0:    a = A_SDA1;
          2'd1:    a = A_SCL1;
          2'd2:    a = A_READ_ACK;
          default: a = A_SCL0;
        endcase
      end
      default: begin
        // start, also used as repeated start
        case (step)
          2'd0:    a = A_SDA1;
          2'd1:    a = A_SCL1;
          2'd2:    a = A_SDA0;
          default: a = A_SCL0;
        endcase
      end
    endcase
    return a;
  endfunction

  function automatic logic [STEP_W-1:0] prog_len(input logic [OP_W-1:0] op);
    logic [STEP_W-1:0] n;
    case (op)
      OP_STOP, OP_WRITE, OP_SACK: n = 4'd3;
      default:                    n = 4'd4;
    endcase
    return n;
  endfunction

  function automatic logic prog_loops(input logic [OP_W-1:0] op);
    return (op == OP_WRITE) || (op == OP_READ);
  endfunction

  function automatic logic [STEP_W-1:0] loop_start(input logic [OP_W-1:0] op);
    return (op == OP_READ) ? 4'd1 : ST_FIRST;
  endfunction

endpackage

`default_nettype wire

// ===== sv/i2cms_if.sv =====
// ----------------------------------------------------------------------------
// i2cms_if
// Valid/ready channels for tick transactions and result transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cms_in_if;
  logic                           valid;
  logic                           ready;
  logic                           cmd_valid;
  logic [i2cms_pkg::OP_W-1:0]     opcode;
  logic [i2cms_pkg::BYTE_W-1:0]   tx_byte;
  logic                           tx_ack;
  logic                           sda_in;

  modport source (output valid, cmd_valid, opcode, tx_byte, tx_ack, sda_in, input ready);
  modport sink   (input valid, cmd_valid, opcode, tx_byte, tx_ack, sda_in, output ready);
endinterface

interface i2cms_out_if;
  logic                           valid;
  logic                           ready;
  logic                           scl_out;
  logic                           sda_out;
  logic                           busy_res;
  logic                           done_res;
  logic [i2cms_pkg::BYTE_W-1:0]   rx_byte;
  logic                           rx_ack;

  modport source (output valid, scl_out, sda_out, busy_res, done_res, rx_byte, rx_ack,
                  input ready);
  modport sink   (input valid, scl_out, sda_out, busy_res, done_res, rx_byte, rx_ack,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/i2cms_step.sv =====
// ----------------------------------------------------------------------------
// i2cms_step
// Next-state logic for one tick: command load, phase hold, one line action.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_step (
  input  i2cms_pkg::seq_state_t                  cur,
  input  i2cms_pkg::cmd_t                        cmd,
  input  logic [i2cms_pkg::PHASE_W-1:0]          phase_ticks,
  output i2cms_pkg::seq_state_t                  nxt,
  output logic                                   done
);

  always_comb begin
    logic                                run;
    i2cms_pkg::act_t                     act;
    logic [i2cms_pkg::STEP_W-1:0]        step_inc;
    logic [i2cms_pkg::BIT_IDX_W-1:0]     bit_sel;

    nxt      = cur;
    run      = 1'b0;
    done     = 1'b0;
    act      = i2cms_pkg::A_SDA1;
    step_inc = '0;
    bit_sel  = '0;

    if (cur.seq_step == i2cms_pkg::ST_IDLE) begin
      // commands are taken only while idle; unknown opcodes are dropped
      if (cmd.cmd_valid && (cmd.opcode <= i2cms_pkg::OP_RACK)) begin
        nxt.current_op  = cmd.opcode;
        nxt.seq_step    = i2cms_pkg::ST_FIRST;
        nxt.bit_index   = '0;
        nxt.phase_count = '0;
        nxt.shift_out   = (cmd.opcode == i2cms_pkg::OP_SACK) ?
                          {{(i2cms_pkg::BYTE_W-1){1'b0}}, cmd.tx_ack} : cmd.tx_byte;
        if (cmd.opcode == i2cms_pkg::OP_READ) begin
          nxt.shift_in = '0;
        end
        run = 1'b1;
      end
    end else if (cur.phase_count != '0) begin
      nxt.phase_count = cur.phase_count - 1'b1;
    end else begin
      run = (cur.seq_step < i2cms_pkg::ST_FINAL);
    end

    if (run) begin
      act     = i2cms_pkg::action_at(nxt.current_op, nxt.seq_step[1:0]);
      bit_sel = i2cms_pkg::LAST_BIT - nxt.bit_index;
      case (act)
        i2cms_pkg::A_SDA0:     nxt.sda_level = 1'b0;
        i2cms_pkg::A_SDA1:     nxt.sda_level = 1'b1;
        i2cms_pkg::A_SDA_BIT:  nxt.sda_level = nxt.shift_out[bit_sel];
        i2cms_pkg::A_SDA_ACK:  nxt.sda_level = nxt.shift_out[0];
        i2cms_pkg::A_SCL0:     nxt.scl_level = 1'b0;
        i2cms_pkg::A_SCL1:     nxt.scl_level = 1'b1;
        i2cms_pkg::A_READ_BIT: begin
          if (cmd.sda_in) begin
            nxt.shift_in[bit_sel] = 1'b1;
          end
        end
        default:               nxt.ack_seen = cmd.sda_in;
      endcase

      // a zero hold count behaves as one tick
      nxt.phase_count = (phase_ticks == '0) ? '0 : phase_ticks - 1'b1;

      step_inc = nxt.seq_step + 1'b1;
      if (step_inc >= i2cms_pkg::prog_len(nxt.current_op)) begin
        if (i2cms_pkg::prog_loops(nxt.current_op) && (nxt.bit_index < i2cms_pkg::LAST_BIT)) begin
          nxt.bit_index = nxt.bit_index + 1'b1;
          nxt.seq_step  = i2cms_pkg::loop_start(nxt.current_op);
        end else begin
          nxt.seq_step = i2cms_pkg::ST_FINAL;
        end
      end else begin
        nxt.seq_step = step_inc;
      end
    end

    if ((nxt.seq_step == i2cms_pkg::ST_FINAL) && (nxt.phase_count == '0)) begin
      nxt.seq_step = i2cms_pkg::ST_IDLE;
      done         = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== sv/i2c_master_bit_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_top
// Open-drain I2C master bit sequencer, one timing tick per transaction.
// ----------------------------------------------------------------------------
// Each input transaction is one timing tick: it carries the sampled SDA level
// and, optionally, a command (start/repeated start, stop, write byte, read
// byte, send ack, receive ack). The block takes one tick per clock cycle and
// returns one result transaction per tick, in the cycle after acceptance, from
// the state register; a new tick is accepted whenever the result register is
// empty or being drained in the same cycle. A command of n line actions takes
// n*phase_ticks ticks (n when phase_ticks is 0) and raises done_res on its
// last tick; commands that arrive while busy (including on the done tick) are
// ignored. phase_ticks is written via cfg_wr_en/cfg_wr_data and resets to 10.
`default_nettype none

module i2c_master_bit_sequencer_top (
  input  logic                              clk,
  input  logic                              rst_n,
  i2cms_in_if.sink                          in_ch,
  i2cms_out_if.source                       out_ch,
  input  logic                              cfg_wr_en,
  input  logic [i2cms_pkg::PHASE_W-1:0]     cfg_wr_data
);

  i2cms_pkg::seq_state_t            state_r;
  i2cms_pkg::seq_state_t            state_nxt;
  i2cms_pkg::cmd_t                  cmd;
  logic                             done_r;
  logic                             done_nxt;
  logic                             out_valid_r;
  logic [i2cms_pkg::PHASE_W-1:0]    phase_ticks_r;
  logic                             in_fire;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign cmd.cmd_valid = in_ch.cmd_valid;
  assign cmd.opcode    = in_ch.opcode;
  assign cmd.tx_byte   = in_ch.tx_byte;
  assign cmd.tx_ack    = in_ch.tx_ack;
  assign cmd.sda_in    = in_ch.sda_in;

  i2cms_step u_step (
    .cur         (state_r),
    .cmd         (cmd),
    .phase_ticks (phase_ticks_r),
    .nxt         (state_nxt),
    .done        (done_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= i2cms_pkg::PHASE_RESET;
    end else if (cfg_wr_en) begin
      phase_ticks_r <= cfg_wr_data;
    end
  end

  // state doubles as the result register: it only moves on an accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.seq_step    <= i2cms_pkg::ST_IDLE;
      state_r.current_op  <= '0;
      state_r.bit_index   <= '0;
      state_r.shift_out   <= '0;
      state_r.shift_in    <= '0;
      state_r.phase_count <= '0;
      state_r.scl_level   <= 1'b1;
      state_r.sda_level   <= 1'b1;
      state_r.ack_seen    <= 1'b1;
      done_r              <= 1'b0;
      out_valid_r         <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r <= state_nxt;
        done_r  <= done_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.scl_out  = state_r.scl_level;
  assign out_ch.sda_out  = state_r.sda_level;
  assign out_ch.busy_res = (state_r.seq_step != i2cms_pkg::ST_IDLE);
  assign out_ch.done_res = done_r;
  assign out_ch.rx_byte  = state_r.shift_in;
  assign out_ch.rx_ack   = state_r.ack_seen;

endmodule

`default_nettype wire

// ===== sv/i2cms_checker.sv =====
// ----------------------------------------------------------------------------
// i2cms_checker
// Port-level checks for the I2C master bit sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             busy_res,
  input logic                             done_res,
  input logic [i2cms_pkg::BYTE_W-1:0]     rx_byte
);

  // an empty result slot never blocks the input side
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while result register empty");

  // every accepted tick yields a result transaction next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted tick produced no result");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(busy_res) &&
                                   $stable(done_res) && $stable(rx_byte)))
    else $error("stalled result changed");

  // a command never finishes and stays busy at once
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && done_res) |-> !busy_res)
    else $error("done while still busy");

  // reset empties the result register
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind i2c_master_bit_sequencer_top i2cms_checker u_i2cms_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .busy_res  (out_ch.busy_res),
  .done_res  (out_ch.done_res),
  .rx_byte   (out_ch.rx_byte)
);

`default_nettype wire

// ===== tb/sv/i2cms_line_checker.sv =====
// ----------------------------------------------------------------------------
// i2cms_line_checker
// Predicts the bus view of the bit sequencer for every accepted tick and
// compares it with each accepted result transaction, in order.
// ----------------------------------------------------------------------------
module i2cms_line_checker
  import i2cms_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  i2cms_in_if                in_ch,
  i2cms_out_if               out_ch,
  input  logic               cfg_wr_en,
  input  logic [PHASE_W-1:0] cfg_wr_data,
  output int                 fail_count,
  output int                 outstanding,
  output int                 cmds_started
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic              scl_out;
    logic              sda_out;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] rx_byte;
    logic              rx_ack;
  } bus_view_t;

  bus_view_t expected_views[$];

  // sequencer model state
  logic [STEP_W-1:0]  step_q;
  logic [OP_W-1:0]    op_q;
  logic [3:0]         bit_pos;
  logic [BYTE_W-1:0]  tx_shift;
  logic [BYTE_W-1:0]  rx_shift;
  logic [PHASE_W-1:0] hold_cnt;
  logic [PHASE_W-1:0] phase_len;
  logic               scl_lvl;
  logic               sda_lvl;
  logic               ack_lvl;

  // line action for slot idx of the command body
  function automatic act_t body_action(logic [OP_W-1:0] op, logic [1:0] idx);
    act_t a;
    case ({op, idx})
      {OP_START, 2'd0}, {OP_READ, 2'd0}, {OP_RACK, 2'd0}, {OP_STOP, 2'd2}: a = A_SDA1;
      {OP_START, 2'd1}, {OP_STOP, 2'd1}, {OP_WRITE, 2'd1}, {OP_READ, 2'd1},
      {OP_SACK, 2'd1}, {OP_RACK, 2'd1}:                                   a = A_SCL1;
      {OP_START, 2'd2}, {OP_STOP, 2'd0}:                                  a = A_SDA0;
      {OP_WRITE, 2'd0}:                                                   a = A_SDA_BIT;
      {OP_SACK, 2'd0}:                                                    a = A_SDA_ACK;
      {OP_READ, 2'd2}:                                                    a = A_READ_BIT;
      {OP_RACK, 2'd2}:                                                    a = A_READ_ACK;
      default:                                                            a = A_SCL0;
    endcase
    return a;
  endfunction

  function automatic logic [STEP_W-1:0] body_len(logic [OP_W-1:0] op);
    return (op == OP_STOP || op == OP_WRITE || op == OP_SACK) ? 4'd3 : 4'd4;
  endfunction

  task automatic advance_sequencer(input cmd_t t);
    bus_view_t    v;
    logic         holding;
    logic         finished;
    logic [7:0]   mask;
    holding  = 1'b0;
    finished = 1'b0;
    if (step_q == ST_IDLE) begin
      if (t.cmd_valid && t.opcode <= OP_RACK) begin
        op_q     = t.opcode;
        step_q   = ST_FIRST;
        bit_pos  = '0;
        hold_cnt = '0;
        tx_shift = (t.opcode == OP_SACK) ? {7'd0, t.tx_ack} : t.tx_byte;
        if (t.opcode == OP_READ) rx_shift = 8'h00;
        cmds_started++;
      end
    end else if (hold_cnt != 0) begin
      hold_cnt--;
      holding = 1'b1;
    end
    if (!holding && step_q < ST_FINAL) begin
      mask = 8'h80 >> bit_pos;
      case (body_action(op_q, step_q[1:0]))
        A_SDA0:     sda_lvl = 1'b0;
        A_SDA1:     sda_lvl = 1'b1;
        A_SDA_BIT:  sda_lvl = |(tx_shift & mask);
        A_SDA_ACK:  sda_lvl = tx_shift[0];
        A_SCL0:     scl_lvl = 1'b0;
        A_SCL1:     scl_lvl = 1'b1;
        A_READ_BIT: if (t.sda_in) rx_shift = rx_shift | mask;
        default:    ack_lvl = t.sda_in;
      endcase
      hold_cnt = (phase_len == 0) ? '0 : phase_len - 1'b1;
      step_q   = step_q + 1'b1;
      if (step_q >= body_len(op_q)) begin
        // byte commands repeat their body once per bit, read skips the SDA release
        if ((op_q == OP_WRITE || op_q == OP_READ) && bit_pos < 4'd7) begin
          bit_pos = bit_pos + 1'b1;
          step_q  = (op_q == OP_READ) ? 4'd1 : ST_FIRST;
        end else begin
          step_q = ST_FINAL;
        end
      end
    end
    if (step_q == ST_FINAL && hold_cnt == 0) begin
      step_q   = ST_IDLE;
      finished = 1'b1;
    end
    v.scl_out  = scl_lvl;
    v.sda_out  = sda_lvl;
    v.busy_res = (step_q != ST_IDLE);
    v.done_res = finished;
    v.rx_byte  = rx_shift;
    v.rx_ack   = ack_lvl;
    expected_views.push_back(v);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      // keep the log readable when everything goes wrong
      if (fail_count < MAX_REPORTS)
        $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic compare_result();
    bus_view_t want;
    if (expected_views.size() == 0) begin
      if (fail_count < MAX_REPORTS) $error("result transaction with nothing expected");
      fail_count++;
    end else begin
      want = expected_views.pop_front();
      check_field("scl_out",  {7'd0, want.scl_out},  {7'd0, out_ch.scl_out});
      check_field("sda_out",  {7'd0, want.sda_out},  {7'd0, out_ch.sda_out});
      check_field("busy_res", {7'd0, want.busy_res}, {7'd0, out_ch.busy_res});
      check_field("done_res", {7'd0, want.done_res}, {7'd0, out_ch.done_res});
      check_field("rx_byte",  want.rx_byte,          out_ch.rx_byte);
      check_field("rx_ack",   {7'd0, want.rx_ack},   {7'd0, out_ch.rx_ack});
    end
  endtask

  always @(posedge clk) begin
    cmd_t t;
    if (!rst_n) begin
      step_q       = ST_IDLE;
      op_q         = '0;
      bit_pos      = '0;
      tx_shift     = '0;
      rx_shift     = '0;
      hold_cnt     = '0;
      phase_len    = PHASE_RESET;
      scl_lvl      = 1'b1;
      sda_lvl      = 1'b1;
      ack_lvl      = 1'b1;
      fail_count   = 0;
      cmds_started = 0;
      expected_views.delete();
    end else begin
      // results first, so one arriving with nothing queued is not hidden
      if (out_ch.valid && out_ch.ready) compare_result();
      if (in_ch.valid && in_ch.ready) begin
        t.cmd_valid = in_ch.cmd_valid;
        t.opcode    = in_ch.opcode;
        t.tx_byte   = in_ch.tx_byte;
        t.tx_ack    = in_ch.tx_ack;
        t.sda_in    = in_ch.sda_in;
        advance_sequencer(t);
      end
      if (cfg_wr_en) phase_len = cfg_wr_data;
    end
    outstanding = expected_views.size();
  end

endmodule

// ===== tb/sv/tb_i2c_master_bit_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// tb_i2c_master_bit_sequencer_top
// Tick stimulus, idling control and verdict for the I2C bit sequencer.
// ----------------------------------------------------------------------------
// Feeds timing ticks carrying commands and SDA samples, with each command placed
// on a tick after the previous one completes; busy ticks and idle ticks carry random
// commands that must be dropped. A directed pass covers each opcode and the
// corner values, then random bus sessions and noise run under several phase
// lengths and idling mixes. The checker predicts every result transaction.
module tb_i2c_master_bit_sequencer_top;
  import i2cms_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [OP_W-1:0] OP_UNUSED6 = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED7 = 3'd7;

  typedef enum logic [1:0] {SDA_LOW, SDA_HIGH, SDA_RAND} sda_pat_t;
  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_SINK, IDLE_BOTH} idle_mix_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [PHASE_W-1:0] cfg_wr_data;
  logic [PHASE_W-1:0] cur_phase;

  int send_gap_pct;
  int sink_stall_pct;
  int ticks_sent;
  int n_in;
  int n_out;
  int stall_cycles;
  int fail_count;
  int outstanding;
  int cmds_started;

  i2cms_in_if  in_if ();
  i2cms_out_if out_if ();

  i2c_master_bit_sequencer_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  i2cms_line_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_if),
    .out_ch       (out_if),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .cmds_started (cmds_started)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // transaction counters and watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      n_in         <= 0;
      n_out        <= 0;
      stall_cycles <= 0;
    end else begin
      if (in_if.valid && in_if.ready) n_in <= n_in + 1;
      if (out_if.valid && out_if.ready) n_out <= n_out + 1;
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
        $error("no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic set_idling(input idle_mix_t mix);
    case (mix)
      IDLE_NONE: begin send_gap_pct = 0;  sink_stall_pct = 0;  end
      IDLE_SEND: begin send_gap_pct = 55; sink_stall_pct = 0;  end
      IDLE_SINK: begin send_gap_pct = 0;  sink_stall_pct = 55; end
      default:   begin send_gap_pct = 22; sink_stall_pct = 22; end
    endcase
  endtask

  task automatic send_tick(input cmd_t t);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.cmd_valid <= t.cmd_valid;
    in_if.opcode    <= t.opcode;
    in_if.tx_byte   <= t.tx_byte;
    in_if.tx_ack    <= t.tx_ack;
    in_if.sda_in    <= t.sda_in;
    in_if.valid     <= 1'b1;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    ticks_sent++;
  endtask

  // sequencer must be idle: lower valid, drain results, then write
  task automatic set_phase(input int unsigned v);
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (n_out != n_in) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= PHASE_W'(v);
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    cur_phase = PHASE_W'(v);
  endtask

  // ticks with no command, or with an opcode the block must drop
  task automatic idle_ticks(input int unsigned count);
    cmd_t t;
    repeat (count) begin
      t.cmd_valid = 1'($urandom_range(1));
      t.opcode    = t.cmd_valid ? OP_W'($urandom_range(OP_UNUSED6, OP_UNUSED7))
                                : OP_W'($urandom_range(7));
      t.tx_byte   = BYTE_W'($urandom);
      t.tx_ack    = 1'($urandom_range(1));
      t.sda_in    = 1'($urandom_range(1));
      send_tick(t);
    end
  endtask

  function automatic int unsigned cmd_actions(input logic [OP_W-1:0] op);
    case (op)
      OP_START, OP_RACK: return 4;
      OP_STOP, OP_SACK:  return 3;
      OP_WRITE:          return 24;
      OP_READ:           return 25;
      default:           return 1;
    endcase
  endfunction

  // issue a command on an idle tick, then cover its whole duration
  task automatic run_cmd(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data,
                         input logic ack_bit, input sda_pat_t pat, input logic noisy);
    int unsigned n;
    int unsigned k;
    cmd_t t;
    if (noisy && $urandom_range(4) == 0) idle_ticks($urandom_range(1, 3));
    n = cmd_actions(op);
    if (op <= OP_RACK) n = n * ((cur_phase == '0) ? 1 : cur_phase);
    for (k = 0; k < n; k++) begin
      t.sda_in = (pat == SDA_RAND) ? 1'($urandom_range(1)) : (pat == SDA_HIGH);
      if (k == 0) begin
        t.cmd_valid = 1'b1;
        t.opcode    = op;
        t.tx_byte   = data;
        t.tx_ack    = ack_bit;
      end else begin
        // busy ticks; the last one is the done tick, which must also drop commands
        t.cmd_valid = noisy && (k == n - 1 || $urandom_range(1) == 1);
        t.opcode    = OP_W'($urandom_range(7));
        t.tx_byte   = BYTE_W'($urandom);
        t.tx_ack    = 1'($urandom_range(1));
      end
      send_tick(t);
    end
  endtask

  task automatic bus_session();
    int unsigned nbytes;
    logic        reading;
    run_cmd(OP_START, BYTE_W'($urandom), 1'($urandom_range(1)), SDA_RAND, 1'b1);
    run_cmd(OP_WRITE, BYTE_W'($urandom), 1'($urandom_range(1)), SDA_RAND, 1'b1);
    run_cmd(OP_RACK, BYTE_W'($urandom), 1'($urandom_range(1)), SDA_RAND, 1'b1);
    if ($urandom_range(3) == 0) begin
      // repeated start with a fresh address
      run_cmd(OP_START, BYTE_W'($urandom), 1'($urandom_range(1)), SDA_RAND, 1'b1);
      run_cmd(OP_WRITE, BYTE_W'($urandom), 1'($urandom_range(1)), SDA_RAND, 1'b1);
      run_cmd(OP_RACK, BYTE_W'($urandom), 1'($urandom_range(1)), SDA_RAND, 1'b1);
    end
    nbytes  = $urandom_range(1, 2);
    reading = 1'($urandom_range(1));
    for (int unsigned j = 0; j < nbytes; j++) begin
      if (reading) begin
        run_cmd(OP_READ, BYTE_W'($urandom), 1'($urandom_range(1)), SDA_RAND, 1'b1);
        run_cmd(OP_SACK, BYTE_W'($urandom), (j == nbytes - 1), SDA_RAND, 1'b1);
      end else begin
        run_cmd(OP_WRITE, BYTE_W'($urandom), 1'($urandom_range(1)), SDA_RAND, 1'b1);
        run_cmd(OP_RACK, BYTE_W'($urandom), 1'($urandom_range(1)), SDA_RAND, 1'b1);
      end
    end
    run_cmd(OP_STOP, BYTE_W'($urandom), 1'($urandom_range(1)), SDA_RAND, 1'b1);
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 4))
      run_cmd(OP_W'($urandom_range(7)), BYTE_W'($urandom), 1'($urandom_range(1)),
              SDA_RAND, 1'b1);
  endtask

  initial begin
    cmd_t t;
    int   phase_start;
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    cur_phase       = PHASE_RESET;
    send_gap_pct    = 0;
    sink_stall_pct  = 0;
    ticks_sent      = 0;
    in_if.valid     = 1'b0;
    in_if.cmd_valid = 1'b0;
    in_if.opcode    = OP_START;
    in_if.tx_byte   = '0;
    in_if.tx_ack    = 1'b0;
    in_if.sda_in    = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset phase length first
    set_idling(IDLE_NONE);
    run_cmd(OP_START, 8'h00, 1'b0, SDA_RAND, 1'b0);
    set_phase(1);
    run_cmd(OP_WRITE, 8'h00, 1'b0, SDA_RAND, 1'b0);
    run_cmd(OP_WRITE, 8'hFF, 1'b1, SDA_RAND, 1'b0);
    run_cmd(OP_WRITE, 8'hA5, 1'b0, SDA_RAND, 1'b1);
    run_cmd(OP_RACK, 8'h00, 1'b0, SDA_LOW, 1'b0);
    run_cmd(OP_RACK, 8'h00, 1'b0, SDA_HIGH, 1'b0);
    run_cmd(OP_READ, 8'h00, 1'b0, SDA_HIGH, 1'b0);
    run_cmd(OP_READ, 8'hFF, 1'b1, SDA_LOW, 1'b0);
    run_cmd(OP_READ, 8'h5A, 1'b0, SDA_RAND, 1'b1);
    run_cmd(OP_SACK, 8'hFF, 1'b0, SDA_RAND, 1'b0);
    run_cmd(OP_SACK, 8'h00, 1'b1, SDA_RAND, 1'b0);
    run_cmd(OP_UNUSED6, 8'hFF, 1'b1, SDA_RAND, 1'b0);
    run_cmd(OP_UNUSED7, 8'h00, 1'b0, SDA_RAND, 1'b0);
    // a valid opcode without the command flag must not start anything
    t = '{cmd_valid: 1'b0, opcode: OP_WRITE, tx_byte: 8'hFF, tx_ack: 1'b1, sda_in: 1'b0};
    send_tick(t);
    run_cmd(OP_STOP, 8'h00, 1'b0, SDA_RAND, 1'b0);
    set_phase(0);
    run_cmd(OP_START, 8'h00, 1'b0, SDA_RAND, 1'b0);
    run_cmd(OP_STOP, 8'h00, 1'b0, SDA_RAND, 1'b0);

    // random sessions, one phase per idling mix
    for (int ph = 0; ph < 4; ph++) begin
      set_idling(idle_mix_t'(ph));
      set_phase((ph == 3) ? 2 : 1);
      phase_start = ticks_sent;
      while (ticks_sent - phase_start < 50) begin
        if ($urandom_range(4) == 0) noise_burst();
        else bus_session();
      end
    end

    @(negedge clk);
    in_if.valid <= 1'b0;
    while (n_out != n_in) @(posedge clk);
    repeat (5) @(posedge clk);
    $display("Covered %0d ticks and %0d started commands, every opcode and both unused codes,",
             n_in, cmds_started);
    $display("at phase lengths 0, 1, 2 and 10 under four idling mixes");
    if (fail_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== i2c_master_bit_sequencer_top.f =====
sv/i2cms_pkg.sv
sv/i2cms_if.sv
sv/i2cms_step.sv
sv/i2c_master_bit_sequencer_top.sv
sv/i2cms_checker.sv
tb/sv/i2cms_line_checker.sv
tb/sv/tb_i2c_master_bit_sequencer_top.sv
